// File: src/rtd_pkg.sv
// Shared constants, types and helpers for the RTD code-to-temperature pipeline.
package rtd_pkg;

   localparam int CODE_BITS_DEFAULT = 15;
   localparam int RES_W     = 24;
   localparam int COEF_W    = 40;
   localparam int TEMP_W    = 19;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 40;

   localparam logic [CSR_IDX_W-1:0] CSR_REF_RES = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NOM_RES = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_0  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_1  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_2  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_3  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_4  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_5  = 3'd7;

   localparam logic [RES_W-1:0]  REF_RES_RESET = 24'd110080;
   localparam logic [RES_W-1:0]  NOM_RES_RESET = 24'd25600;
   localparam logic [COEF_W-1:0] COEF_0_RESET  = -40'sd15860897;
   localparam logic [COEF_W-1:0] COEF_1_RESET  = 40'sd37291599;
   localparam logic [COEF_W-1:0] COEF_2_RESET  = 40'sd11106343;
   localparam logic [COEF_W-1:0] COEF_3_RESET  = 40'sd5306327;
   localparam logic [COEF_W-1:0] COEF_4_RESET  = 40'sd7934220;
   localparam logic [COEF_W-1:0] COEF_5_RESET  = 40'sd10983770;

   // quadratic path constants
   localparam logic [63:0] QA     = 64'd7816600;
   localparam logic [63:0] QK     = 64'd9240000000000;
   localparam logic [63:0] A2F    = (64'd7816600 * 64'd7816600) << 18;
   localparam logic [63:0] DMAX   = A2F / QK;
   localparam logic [63:0] QBASE  = QA * 64'd512 + 64'd2310;
   localparam int          QDIV   = 4620;

   localparam int SQRT_W  = 32;  // result bits of isqrt over a 64-bit radicand
   localparam int DIV_W   = 32;  // quotient bits of numerator/den division

   localparam logic signed [COEF_W-1:0] P_MAX = {1'b0, {(COEF_W-1){1'b1}}};
   localparam logic signed [COEF_W-1:0] P_MIN = {1'b1, {(COEF_W-1){1'b0}}};

   // Clamp a wide signed value into 40 bits.
   function automatic logic signed [COEF_W-1:0] sat40(input logic signed [63:0] v);
      logic signed [COEF_W-1:0] r;
      if (v > 64'sd549755813887)       r = P_MAX;
      else if (v < -64'sd549755813888) r = P_MIN;
      else                             r = v[COEF_W-1:0];
      return r;
   endfunction

   typedef struct packed {
      logic [RES_W-1:0]  ref_res;
      logic [RES_W-1:0]  nom_res;
      logic [COEF_W-1:0] c0;
      logic [COEF_W-1:0] c1;
      logic [COEF_W-1:0] c2;
      logic [COEF_W-1:0] c3;
      logic [COEF_W-1:0] c4;
      logic [COEF_W-1:0] c5;
   } cfg_type;

   // pipeline control shared by every stage: request accepted and advance enable
   typedef struct packed {
      logic valid;
      logic advance;
   } stage_ctl_type;

endpackage

// File: src/rtd_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module rtd_div #(
   parameter int NUM_W = 64,
   parameter int DEN_W = 40,
   parameter int Q_W   = 32,
   parameter int TAG_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [Q_W-1:0]   out_quo,
   output logic             out_ovf,
   output logic [TAG_W-1:0] out_tag
);
   // quotient limited to Q_W bits: overflow flagged when num >= den << Q_W
   logic [NUM_W+Q_W-1:0] rem_ff [Q_W+1];
   logic [DEN_W-1:0]     den_ff [Q_W+1];
   logic [Q_W-1:0]       quo_ff [Q_W+1];
   logic [TAG_W-1:0]     tag_ff [Q_W+1];
   logic                 ovf_ff [Q_W+1];
   logic                 vld_ff [Q_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= Q_W; i++) vld_ff[i] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= in_valid;
         for (int i = 1; i <= Q_W; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0] <= {{Q_W{1'b0}}, in_num};
         den_ff[0] <= in_den;
         tag_ff[0] <= in_tag;
         quo_ff[0] <= '0;
         ovf_ff[0] <= ({{Q_W{1'b0}}, in_num} >=
                       ({{(NUM_W+Q_W-DEN_W){1'b0}}, in_den} << Q_W));
         for (int i = 1; i <= Q_W; i++) begin
            logic [NUM_W+Q_W-1:0] sh;
            sh = {{(NUM_W+Q_W-DEN_W){1'b0}}, den_ff[i-1]} << (Q_W - i);
            if (rem_ff[i-1] >= sh) begin
               rem_ff[i] <= rem_ff[i-1] - sh;
               quo_ff[i] <= quo_ff[i-1] | (Q_W'(1) << (Q_W - i));
            end else begin
               rem_ff[i] <= rem_ff[i-1];
               quo_ff[i] <= quo_ff[i-1];
            end
            den_ff[i] <= den_ff[i-1];
            tag_ff[i] <= tag_ff[i-1];
            ovf_ff[i] <= ovf_ff[i-1];
         end
      end
   end

   assign out_valid = vld_ff[Q_W];
   assign out_quo   = quo_ff[Q_W];
   assign out_ovf   = ovf_ff[Q_W];
   assign out_tag   = tag_ff[Q_W];
endmodule

// File: src/rtd_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module rtd_sqrt #(
   parameter int TAG_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  logic [63:0]      in_rad,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [31:0]      out_root,
   output logic [TAG_W-1:0] out_tag
);
   logic [63:0]      rem_ff [33];
   logic [31:0]      root_ff [33];
   logic [TAG_W-1:0] tag_ff [33];
   logic             vld_ff [33];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= 32; i++) vld_ff[i] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= in_valid;
         for (int i = 1; i <= 32; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // trial: (2*root*2^k + 4^k) <= rem, with k from 31 down to 0
   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0]  <= in_rad;
         root_ff[0] <= '0;
         tag_ff[0]  <= in_tag;
         for (int i = 1; i <= 32; i++) begin
            logic [65:0] trial;
            trial = ({34'd0, root_ff[i-1]} << (33 - i)) + (66'd1 << (2 * (32 - i)));
            if ({2'b00, rem_ff[i-1]} >= trial) begin
               rem_ff[i]  <= rem_ff[i-1] - trial[63:0];
               root_ff[i] <= root_ff[i-1] | (32'd1 << (32 - i));
            end else begin
               rem_ff[i]  <= rem_ff[i-1];
               root_ff[i] <= root_ff[i-1];
            end
            tag_ff[i] <= tag_ff[i-1];
         end
      end
   end

   assign out_valid = vld_ff[32];
   assign out_root  = root_ff[32];
   assign out_tag   = tag_ff[32];
endmodule

// File: src/rtd_horner.sv
// Five-step Horner evaluation, multiply and add on separate stages.
module rtd_horner (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic                            in_valid,
   input  logic [rtd_pkg::RES_W-1:0]       in_r,
   input  rtd_pkg::cfg_type                cfg,
   output logic                            out_valid,
   output logic signed [rtd_pkg::COEF_W-1:0] out_p
);
   import rtd_pkg::*;

   // step j: multiply stage 2j+1, add stage 2j+2 (stage 0 loads c5 and r)
   logic signed [COEF_W-1:0] p_ff   [6];
   logic signed [63:0]       m_ff   [5];
   logic [RES_W-1:0]         r_ff   [11];
   logic                     vld_ff [11];
   logic signed [COEF_W-1:0] cc     [5];
   logic                     sub    [5];

   always_comb begin
      cc[0] = cfg.c4; sub[0] = 1'b1;
      cc[1] = cfg.c3; sub[1] = 1'b1;
      cc[2] = cfg.c2; sub[2] = 1'b0;
      cc[3] = cfg.c1; sub[3] = 1'b0;
      cc[4] = cfg.c0; sub[4] = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= 10; i++) vld_ff[i] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= in_valid;
         for (int i = 1; i <= 10; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         r_ff[0] <= in_r;
         p_ff[0] <= cfg.c5;
         for (int i = 1; i <= 10; i++) r_ff[i] <= r_ff[i-1];
         for (int j = 0; j < 5; j++) begin
            logic signed [63:0] sh;
            logic signed [63:0] acc;
            m_ff[j] <= 64'(p_ff[j]) * $signed({1'b0, r_ff[2*j]});
            sh  = m_ff[j] >>> 22;
            acc = sub[j] ? sh - 64'(cc[j]) : sh + 64'(cc[j]);
            p_ff[j+1] <= sat40(acc);
         end
      end
   end

   assign out_valid = vld_ff[10];
   assign out_p     = p_ff[5];
endmodule

// File: src/rtd_code_to_temperature.sv
// Top level: RTD ratio code to temperature, Callendar-Van Dusen inverse pipeline.
//
// Requests enter on req_ (valid/ready, one adc_code each); results leave on
// rsp_ with temperature in 1/256 degC, a polynomial-path flag and a clamp flag.
// Registers are written on csr_ (index 0..7 per list, 40-bit data); write them
// only while the pipeline is empty.
// Throughput: one request per cycle while the output is not stalled on rsp_ready.
// Depth: 73 register stages between req_ and rsp_. The path: 2 front stages, a
// 33-stage ratio divider, 2 stages for the quadratic select and radicand, a
// 33-stage square root (polynomial runs in parallel, 11 stages plus a 22-stage
// delay line), a 2-stage multiply-by-reciprocal for /4620, and the output register.
// The pipeline advances only while the output register is empty or being
// taken, so a stall on rsp_ready freezes every stage and loses nothing.
// req_ready is high whenever the pipeline can advance, not just when idle.
// Reset (synchronous, active high) empties every stage and restores register
// defaults. Zero nominal resistance is treated as 1/256 ohm.
module rtd_code_to_temperature
   import rtd_pkg::*;
#(
   parameter int CODE_BITS = CODE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CODE_BITS-1:0]  req_adc_code,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [TEMP_W-1:0] rsp_temperature,
   output logic                  rsp_used_polynomial,
   output logic                  rsp_saturated,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DAT_W-1:0]  csr_data
);
   localparam int RQ_W = CODE_BITS + RES_W;

   cfg_type cfg_ff;
   stage_ctl_type ctl;

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{REF_RES_RESET, NOM_RES_RESET, COEF_0_RESET, COEF_1_RESET,
                     COEF_2_RESET, COEF_3_RESET, COEF_4_RESET, COEF_5_RESET};
      end else if (csr_valid) begin
         case (csr_index)
            CSR_REF_RES: cfg_ff.ref_res <= csr_data[RES_W-1:0];
            CSR_NOM_RES: cfg_ff.nom_res <= csr_data[RES_W-1:0];
            CSR_COEF_0:  cfg_ff.c0 <= csr_data;
            CSR_COEF_1:  cfg_ff.c1 <= csr_data;
            CSR_COEF_2:  cfg_ff.c2 <= csr_data;
            CSR_COEF_3:  cfg_ff.c3 <= csr_data;
            CSR_COEF_4:  cfg_ff.c4 <= csr_data;
            CSR_COEF_5:  cfg_ff.c5 <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------- flow control ----------------
   logic out_vld_ff;
   assign ctl.advance = !out_vld_ff || rsp_ready;
   assign req_ready   = ctl.advance;
   assign ctl.valid   = req_valid && req_ready;

   // ---------------- stage A: product and denominator ----------------
   logic            a_vld_ff;
   logic [RQ_W-1:0] a_rq_ff;
   logic [RES_W-1:0] a_rn_ff;
   always_ff @(posedge clock) begin
      if (reset) a_vld_ff <= 1'b0;
      else if (ctl.advance) a_vld_ff <= ctl.valid;
      if (ctl.advance) begin
         a_rq_ff <= RQ_W'(req_adc_code) * RQ_W'(cfg_ff.ref_res);
         a_rn_ff <= (cfg_ff.nom_res == '0) ? RES_W'(1) : cfg_ff.nom_res;
      end
   end

   // ---------------- stage B: numerators ----------------
   // x = rq*2^18/(rn*2^15) = rq*2^3/rn ; r = rq*100*2^14/(rn*2^15) = rq*50/rn
   logic            b_vld_ff;
   logic [63:0]     b_xn_ff, b_rnum_ff;
   logic [RES_W-1:0] b_rn_ff;
   always_ff @(posedge clock) begin
      if (reset) b_vld_ff <= 1'b0;
      else if (ctl.advance) b_vld_ff <= a_vld_ff;
      if (ctl.advance) begin
         b_xn_ff   <= 64'(a_rq_ff) << 3;
         b_rnum_ff <= 64'(a_rq_ff) * 64'd50;
         b_rn_ff   <= a_rn_ff;
      end
   end

   // ---------------- ratio dividers ----------------
   logic        dx_vld, dr_vld, dx_ovf, dr_ovf;
   logic [31:0] dx_q, dr_q;
   logic        dx_tag, dr_tag;

   rtd_div #(.NUM_W(64), .DEN_W(RES_W), .Q_W(DIV_W), .TAG_W(1)) u_div_x (
      .clock, .reset, .advance(ctl.advance), .in_valid(b_vld_ff),
      .in_num(b_xn_ff), .in_den(b_rn_ff), .in_tag(1'b0),
      .out_valid(dx_vld), .out_quo(dx_q), .out_ovf(dx_ovf), .out_tag(dx_tag));
   rtd_div #(.NUM_W(64), .DEN_W(RES_W), .Q_W(DIV_W), .TAG_W(1)) u_div_r (
      .clock, .reset, .advance(ctl.advance), .in_valid(b_vld_ff),
      .in_num(b_rnum_ff), .in_den(b_rn_ff), .in_tag(1'b0),
      .out_valid(dr_vld), .out_quo(dr_q), .out_ovf(dr_ovf), .out_tag(dr_tag));

   // ---------------- stage C: quadratic select and radicand ----------------
   // x fits in 32 bits except on overflow; overflow means huge x -> polynomial
   logic        c_vld_ff, c_poly_ff;
   logic [63:0] c_kd_ff;
   logic [RES_W-1:0] c_r_ff;
   always_ff @(posedge clock) begin
      if (reset) c_vld_ff <= 1'b0;
      else if (ctl.advance) c_vld_ff <= dx_vld && dr_vld;
      if (ctl.advance) begin
         logic [63:0] xw, d;
         xw = {32'd0, dx_q};
         d  = xw - 64'd262144;
         c_poly_ff <= dx_ovf || dx_tag || (xw < 64'd262144) || (d > DMAX);
         c_kd_ff   <= QK * {43'd0, d[20:0]};
         c_r_ff    <= (dr_ovf || dr_tag || dr_q > 32'hFFFFFF) ? {RES_W{1'b1}}
                                                              : dr_q[RES_W-1:0];
      end
   end

   // d <= DMAX < 2^21, so the product fits and the subtraction stays >= 0
   logic        d_vld_ff, d_poly_ff;
   logic [63:0] d_rad_ff;
   logic [RES_W-1:0] d_r_ff;
   always_ff @(posedge clock) begin
      if (reset) d_vld_ff <= 1'b0;
      else if (ctl.advance) d_vld_ff <= c_vld_ff;
      if (ctl.advance) begin
         d_poly_ff <= c_poly_ff;
         d_rad_ff  <= c_poly_ff ? 64'd0 : A2F - c_kd_ff;
         d_r_ff    <= c_r_ff;
      end
   end

   // ---------------- square root and polynomial in parallel ----------------
   logic        s_vld, s_poly;
   logic [31:0] s_root;
   rtd_sqrt #(.TAG_W(1)) u_sqrt (
      .clock, .reset, .advance(ctl.advance), .in_valid(d_vld_ff),
      .in_rad(d_rad_ff), .in_tag(d_poly_ff),
      .out_valid(s_vld), .out_root(s_root), .out_tag(s_poly));

   logic                     h_vld;
   logic signed [COEF_W-1:0] h_p;
   rtd_horner u_horner (
      .clock, .reset, .advance(ctl.advance), .in_valid(d_vld_ff),
      .in_r(d_r_ff), .cfg(cfg_ff), .out_valid(h_vld), .out_p(h_p));

   // delay line for the polynomial result to meet the square root output:
   // the root takes 33 registers, the Horner unit 11
   localparam int PDLY = 33 - 11;
   logic signed [COEF_W-1:0] pd_ff [PDLY];
   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         pd_ff[0] <= h_p;
         for (int i = 1; i < PDLY; i++) pd_ff[i] <= pd_ff[i-1];
      end
   end

   // ---------------- stage E: numerator for /4620 ----------------
   // num < 2^33; q = (num * M) >> 44 with M = ceil(2^44/4620) is exact here
   localparam logic [63:0] RECIP = ((64'd1 << 44) + 64'd4619) / 64'd4620;
   logic        e_vld_ff, e_poly_ff;
   logic [33:0] e_num_ff;
   logic signed [COEF_W-1:0] e_p_ff;
   always_ff @(posedge clock) begin
      if (reset) e_vld_ff <= 1'b0;
      else if (ctl.advance) e_vld_ff <= s_vld;
      if (ctl.advance) begin
         e_poly_ff <= s_poly;
         e_num_ff  <= 34'(QBASE - {32'd0, s_root});
         e_p_ff    <= pd_ff[PDLY-1];
      end
   end

   // rounded polynomial result spans -2^31..2^31, so keep 33 bits
   logic        f_vld_ff, f_poly_ff;
   logic [63:0] f_prod_ff;
   logic signed [32:0] f_pt_ff;
   always_ff @(posedge clock) begin
      if (reset) f_vld_ff <= 1'b0;
      else if (ctl.advance) f_vld_ff <= e_vld_ff;
      if (ctl.advance) begin
         logic signed [COEF_W:0] ps;
         f_poly_ff <= e_poly_ff;
         f_prod_ff <= {30'd0, e_num_ff} * RECIP;
         ps        = (COEF_W+1)'(e_p_ff) + (COEF_W+1)'(128);
         f_pt_ff   <= 33'(ps >>> 8);
      end
   end

   // ---------------- output register: select, clamp ----------------
   logic signed [TEMP_W-1:0] out_t_ff;
   logic out_poly_ff, out_sat_ff;
   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else if (ctl.advance) out_vld_ff <= f_vld_ff;
      if (ctl.advance) begin
         logic signed [32:0] t;
         t = f_poly_ff ? f_pt_ff : $signed({13'd0, f_prod_ff[63:44]});
         out_poly_ff <= f_poly_ff;
         if (t > 33'sd262143) begin
            out_t_ff <= 19'sd262143; out_sat_ff <= 1'b1;
         end else if (t < -33'sd65536) begin
            out_t_ff <= -19'sd65536; out_sat_ff <= 1'b1;
         end else begin
            out_t_ff <= t[TEMP_W-1:0]; out_sat_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid           = out_vld_ff;
   assign rsp_temperature     = out_t_ff;
   assign rsp_used_polynomial = out_poly_ff;
   assign rsp_saturated       = out_sat_ff;

   // ---------------- assertions ----------------
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_temperature))
      else $error("result changed under stall");
   a_ready_tracks: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output");
   a_sat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_temperature == 19'sd262143 || rsp_temperature == -19'sd65536)
      else $error("saturated flag without clamp value");
endmodule

// File: verif/rtd_code_to_temperature_tb.sv
// Self-checking testbench for the RTD ratio code to temperature pipeline.
module rtd_code_to_temperature_tb;
   import rtd_pkg::*;

   // Checked fields of one conversion result.
   typedef struct {
      logic signed [TEMP_W-1:0] temp;
      logic                     poly;
      logic                     clamp;
   } reading_type;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 120;   // comfortably past the pipeline latency
   localparam int HOLD_CYCLES    = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [14:0]            req_adc_code = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic signed [TEMP_W-1:0] rsp_temperature;
   logic                   rsp_used_polynomial;
   logic                   rsp_saturated;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DAT_W-1:0]   csr_data = '0;

   rtd_code_to_temperature dut (.*);

   // Shadow copy of the configuration registers.
   logic [RES_W-1:0] ref_ohms;
   logic [RES_W-1:0] nom_ohms;
   longint           horner_coef [6];

   logic [14:0] codes_to_send [$];
   reading_type readings_due [$];

   int  send_idle_pct  = 0;
   int  recv_stall_pct = 0;
   int  hold_count     = 0;
   logic hold_armed    = 1'b0;
   logic hold_used     = 1'b0;
   int  error_count    = 0;
   int  quiet_cycles   = 0;
   logic req_taken = 1'b0;
   logic csr_taken = 1'b0;

   initial begin
      forever #1 clock = ~clock;
   end

   // Integer square root, bit by bit.
   function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n    -= root + bitv;
            root  = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   // Clamp a Horner partial sum to 40 bits signed.
   function automatic longint clip_horner(input longint v);
      if (v > 64'sd549755813887) return 64'sd549755813887;
      if (v < -64'sd549755813888) return -64'sd549755813888;
      return v;
   endfunction

   // Work out the temperature reading for one ratio code.
   function automatic reading_type convert_code(input logic [14:0] code);
      reading_type     rd;
      longint unsigned rn, rq, den, x, d, a2f, s, r;
      longint          p, t, rs;
      logic            poly;
      rn   = (nom_ohms == 0) ? 64'd1 : 64'(nom_ohms);
      rq   = 64'(code) * 64'(ref_ohms);
      den  = rn * 64'd32768;
      x    = (rq << 18) / den;
      a2f  = (64'd7816600 * 64'd7816600) << 18;
      poly = 1'b1;
      t    = 0;
      if (x >= (64'd1 << 18)) begin
         d = x - (64'd1 << 18);
         if (d <= a2f / 64'd9240000000000) begin
            s    = int_sqrt(a2f - 64'd9240000000000 * d);
            t    = longint'((64'd7816600 * 64'd512 - s + 64'd2310) / 64'd4620);
            poly = 1'b0;
         end
      end
      if (poly) begin
         r = (rq * 64'd100 * 64'd16384) / den;
         if (r > 64'd16777215) r = 64'd16777215;
         rs = longint'(r);
         p  = horner_coef[5];
         p  = clip_horner(((p * rs) >>> 22) - horner_coef[4]);
         p  = clip_horner(((p * rs) >>> 22) - horner_coef[3]);
         p  = clip_horner(((p * rs) >>> 22) + horner_coef[2]);
         p  = clip_horner(((p * rs) >>> 22) + horner_coef[1]);
         p  = clip_horner(((p * rs) >>> 22) + horner_coef[0]);
         t  = (p + 128) >>> 8;
      end
      rd.clamp = 1'b0;
      if (t > 262143) begin
         t = 262143;
         rd.clamp = 1'b1;
      end else if (t < -65536) begin
         t = -65536;
         rd.clamp = 1'b1;
      end
      rd.temp = t[TEMP_W-1:0];
      rd.poly = poly;
      return rd;
   endfunction

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $time, what);
      error_count++;
   endtask

   // Append one code to the list of pending requests.
   task automatic enqueue_code(input logic [14:0] code);
      codes_to_send = {codes_to_send, code};
   endtask

   // Record handshakes and check results at the rising edge.
   always @(posedge clock) begin
      reading_type due;
      req_taken <= !reset && req_valid && req_ready;
      csr_taken <= !reset && csr_valid && csr_ready;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         // predict at acceptance, with the configuration in force now
         if (req_valid && req_ready)
            readings_due = {readings_due, convert_code(req_adc_code)};
         if (rsp_valid && rsp_ready) begin
            if (readings_due.size() == 0) begin
               report_mismatch("result with no request outstanding");
            end else begin
               due = readings_due.pop_front();
               if (rsp_temperature !== due.temp)
                  report_mismatch($sformatf("temperature %0d, want %0d",
                                            rsp_temperature, due.temp));
               if (rsp_used_polynomial !== due.poly)
                  report_mismatch($sformatf("used_polynomial %0b, want %0b",
                                            rsp_used_polynomial, due.poly));
               if (rsp_saturated !== due.clamp)
                  report_mismatch($sformatf("saturated %0b, want %0b",
                                            rsp_saturated, due.clamp));
            end
         end
      end
   end

   // Request driver: hold an offered code until taken, then advance or idle.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_taken)) begin
         if (codes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid    <= 1'b1;
            req_adc_code <= codes_to_send.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: random stalls, plus one long hold-off once it is armed.
   always @(negedge clock) begin
      if (hold_armed && !hold_used) begin
         hold_used  <= 1'b1;
         hold_count <= HOLD_CYCLES - 1;
         rsp_ready  <= 1'b0;
      end else if (hold_count > 0) begin
         rsp_ready  <= 1'b0;
         hold_count <= hold_count - 1;
      end else begin
         rsp_ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // End the run if nothing moves for too long.
   always @(posedge clock) begin
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(negedge clock); while (!csr_taken);
      csr_valid <= 1'b0;
      case (idx)
         CSR_REF_RES: ref_ohms = val[RES_W-1:0];
         CSR_NOM_RES: nom_ohms = val[RES_W-1:0];
         default:     horner_coef[idx - CSR_COEF_0] = longint'($signed(val));
      endcase
   endtask

   // Wait for every request to be answered, then let the pipeline settle.
   task automatic drain();
      while (codes_to_send.size() != 0 || req_valid || readings_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic load_defaults();
      write_reg(CSR_REF_RES, 40'(REF_RES_RESET));
      write_reg(CSR_NOM_RES, 40'(NOM_RES_RESET));
      write_reg(CSR_COEF_0, COEF_0_RESET);
      write_reg(CSR_COEF_1, COEF_1_RESET);
      write_reg(CSR_COEF_2, COEF_2_RESET);
      write_reg(CSR_COEF_3, COEF_3_RESET);
      write_reg(CSR_COEF_4, COEF_4_RESET);
      write_reg(CSR_COEF_5, COEF_5_RESET);
   endtask

   // Queue random codes, mostly near the 0 degC crossover where paths switch.
   task automatic queue_codes(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(2) == 0) enqueue_code(15'($urandom));
         else enqueue_code(15'($urandom_range(8500, 4000)));
      end
   endtask

   initial begin
      int idle_plan [4][2] = '{'{0, 0}, '{63, 0}, '{0, 63}, '{18, 18}};
      ref_ohms = REF_RES_RESET;
      nom_ohms = NOM_RES_RESET;
      horner_coef[0] = longint'($signed(COEF_0_RESET));
      horner_coef[1] = longint'($signed(COEF_1_RESET));
      horner_coef[2] = longint'($signed(COEF_2_RESET));
      horner_coef[3] = longint'($signed(COEF_3_RESET));
      horner_coef[4] = longint'($signed(COEF_4_RESET));
      horner_coef[5] = longint'($signed(COEF_5_RESET));
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: code extremes, both sides of 100 ohm, top of range.
      enqueue_code(15'd0);
      enqueue_code(15'd1);
      enqueue_code(15'd32767);
      enqueue_code(15'd7620);
      enqueue_code(15'd7621);
      enqueue_code(15'd3000);
      enqueue_code(15'd16384);
      enqueue_code(15'd30000);
      drain();
      // Zero nominal resistance counts as 1/256 ohm: huge ratio, r clamps.
      write_reg(CSR_NOM_RES, 40'd0);
      enqueue_code(15'd1);
      enqueue_code(15'd32767);
      drain();
      // Zero and full-scale reference resistor.
      write_reg(CSR_NOM_RES, 40'(NOM_RES_RESET));
      write_reg(CSR_REF_RES, 40'd0);
      enqueue_code(15'd12345);
      drain();
      write_reg(CSR_REF_RES, 40'hFF_FFFF_FFFF);
      enqueue_code(15'd100);
      enqueue_code(15'd32767);
      drain();
      // Extreme coefficients drive the Horner sums and the output into clamp.
      write_reg(CSR_REF_RES, 40'(REF_RES_RESET));
      write_reg(CSR_COEF_5, 40'h7F_FFFF_FFFF);
      write_reg(CSR_COEF_0, 40'h80_0000_0000);
      enqueue_code(15'd7000);
      enqueue_code(15'd200);
      drain();
      write_reg(CSR_COEF_5, 40'h80_0000_0000);
      write_reg(CSR_COEF_4, 40'h7F_FFFF_FFFF);
      write_reg(CSR_COEF_0, 40'h7F_FFFF_FFFF);
      enqueue_code(15'd7000);
      enqueue_code(15'd0);
      drain();

      // Random phases over idling modes and register settings.
      for (int ph = 0; ph < 8; ph++) begin
         load_defaults();
         if (ph % 2 == 1) begin
            write_reg(CSR_REF_RES, 40'($urandom_range(140000, 80000)) | (40'($urandom) << 24));
            write_reg(CSR_NOM_RES, 40'($urandom_range(30000, 20000)));
         end
         if (ph >= 6) begin
            for (int c = 0; c < 6; c++)
               write_reg(CSR_IDX_W'(CSR_COEF_0 + c), {8'($urandom), 32'($urandom)});
            write_reg(CSR_NOM_RES, 40'($urandom));
            write_reg(CSR_REF_RES, 40'($urandom));
         end
         send_idle_pct  = idle_plan[ph % 4][0];
         recv_stall_pct = idle_plan[ph % 4][1];
         queue_codes(52);
         if (ph == 2) begin
            // hold the receiver off long enough for the pipeline to back up
            send_idle_pct  = 0;
            recv_stall_pct = 0;
            queue_codes(120);
            @(negedge clock);
            hold_armed = 1'b1;
         end
         drain();
      end

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
